[src/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Holds the transaction structs, request and status codes, default sizes and
// the controller state type.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned CAPACITY_DEF     = 256;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;
  localparam int unsigned KEY_BITS         = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic [15:0]        payload;
    logic [7:0]         position;
  } skt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] entry_key;
    logic [15:0]        entry_payload;
    logic [8:0]         entry_count;
  } skt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_WR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_WAIT,
    ST_RM_SHIFT,
    ST_DONE
  } skt_state_e;

endpackage

[src/skt_cmp.sv]
// ----------------------------------------------------------------------------
// skt_cmp: shared key comparator
// Signed less-than and equality of the request key against a stored key,
// used by both the insert shift loop and the binary search.
// ----------------------------------------------------------------------------
module skt_cmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               lt_o,
  output logic               eq_o
);
  import skt_pkg::*;

  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

[src/skt_store.sv]
// ----------------------------------------------------------------------------
// skt_store: entry memory
// One write port and one registered read port over the key and payload of
// every table entry.
// ----------------------------------------------------------------------------
module skt_store #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rd_en_i,
  input  logic [$clog2(CAPACITY)-1:0]                rd_addr_i,
  output logic [skt_pkg::KEY_BITS+PAYLOAD_BITS-1:0]  rd_data_o,
  input  logic                                       wr_en_i,
  input  logic [$clog2(CAPACITY)-1:0]                wr_addr_i,
  input  logic [skt_pkg::KEY_BITS+PAYLOAD_BITS-1:0]  wr_data_i
);
  import skt_pkg::*;

  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/skt_ctrl.sv]
// ----------------------------------------------------------------------------
// skt_ctrl: request sequencer
// Steps through insert shifting, binary search probes, remove shifting and
// reads, using the shared comparator.
// ----------------------------------------------------------------------------
module skt_ctrl #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  skt_pkg::skt_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_free_i,
  output skt_pkg::skt_rsp_t rsp_o
);
  import skt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

  skt_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [IW-1:0] mid_q, mid_d;

  logic [1:0]              type_q, type_d;
  logic signed [31:0]      key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [1:0]              st_q, st_d;
  logic [IW-1:0]           fpos_q, fpos_d;
  logic signed [31:0]      okey_q, okey_d;
  logic [PAYLOAD_BITS-1:0] opay_q, opay_d;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic signed [31:0]      rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    key_lt, key_eq;

  logic [31:0]   pin32, pos32, fp32, op32, cnt32;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] count_m1, idx_m1, idx_m2;
  logic [CW:0]   idx_p1, idx_p2;

  assign rd_key   = rd_data[EW-1 -: KEY_BITS];
  assign rd_pay   = rd_data[PAYLOAD_BITS-1:0];
  assign pin32    = 32'(req_i.payload);
  assign pos32    = 32'(req_i.position);
  assign mid_sum  = {1'b0, idx_q} + {1'b0, hi_q};
  assign count_m1 = count_q - CW'(1);
  assign idx_m1   = idx_q - CW'(1);
  assign idx_m2   = idx_q - CW'(2);
  assign idx_p1   = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx_q} + (CW+1)'(2);

  skt_cmp u_cmp (
    .a_i  (key_q),
    .b_i  (rd_key),
    .lt_o (key_lt),
    .eq_o (key_eq)
  );

  skt_store #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    type_q <= type_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    st_q   <= st_d;
    fpos_q <= fpos_d;
    okey_q <= okey_d;
    opay_q <= opay_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    type_d  = type_q;
    key_d   = key_q;
    pay_d   = pay_q;
    st_d    = st_q;
    fpos_d  = fpos_q;
    okey_d  = okey_q;
    opay_d  = opay_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {key_q, pay_q};
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          type_d = req_i.req_type;
          key_d  = req_i.key;
          pay_d  = pin32[PAYLOAD_BITS-1:0];
          st_d   = STAT_OK;
          fpos_d = '0;
          okey_d = '0;
          opay_d = '0;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                st_d    = STAT_FULL;
                state_d = ST_DONE;
              end else if (count_q == '0) begin
                idx_d   = '0;
                state_d = ST_INS_WR;
              end else begin
                idx_d   = count_q;
                rd_en   = 1'b1;
                rd_addr = count_m1[IW-1:0];
                state_d = ST_INS_CMP;
              end
            end
            REQ_SEARCH: begin
              if (count_q == '0) begin
                st_d    = STAT_MISS;
                state_d = ST_DONE;
              end else begin
                idx_d   = '0;
                hi_d    = count_m1;
                state_d = ST_SRCH_RD;
              end
            end
            default: begin
              if (pos32 >= 32'(count_q)) begin
                st_d    = STAT_RANGE;
                state_d = ST_DONE;
              end else begin
                idx_d   = pos32[CW-1:0];
                rd_en   = 1'b1;
                rd_addr = pos32[IW-1:0];
                state_d = ST_RD_WAIT;
              end
            end
          endcase
        end
      end

      ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IW-1:0];
        if (key_lt) begin
          wr_data = rd_data;
          idx_d   = idx_m1;
          if (idx_q > CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx_m2[IW-1:0];
          end else begin
            state_d = ST_INS_WR;
          end
        end else begin
          wr_data = {key_q, pay_q};
          fpos_d  = idx_q[IW-1:0];
          okey_d  = key_q;
          opay_d  = pay_q;
          count_d = count_q + CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IW-1:0];
        wr_data = {key_q, pay_q};
        fpos_d  = idx_q[IW-1:0];
        okey_d  = key_q;
        opay_d  = pay_q;
        count_d = count_q + CW'(1);
        state_d = ST_DONE;
      end

      ST_SRCH_RD: begin
        if (idx_q <= hi_q) begin
          mid_d   = mid_sum[IW:1];
          rd_en   = 1'b1;
          rd_addr = mid_sum[IW:1];
          state_d = ST_SRCH_CMP;
        end else begin
          st_d    = STAT_MISS;
          state_d = ST_DONE;
        end
      end

      ST_SRCH_CMP: begin
        if (key_eq) begin
          fpos_d  = mid_q;
          okey_d  = rd_key;
          opay_d  = rd_pay;
          state_d = ST_DONE;
        end else if (key_lt) begin
          if (mid_q == '0) begin
            st_d    = STAT_MISS;
            state_d = ST_DONE;
          end else begin
            hi_d    = CW'(mid_q) - CW'(1);
            state_d = ST_SRCH_RD;
          end
        end else begin
          idx_d   = CW'(mid_q) + CW'(1);
          state_d = ST_SRCH_RD;
        end
      end

      ST_RD_WAIT: begin
        fpos_d = idx_q[IW-1:0];
        okey_d = rd_key;
        opay_d = rd_pay;
        if (type_q == REQ_READ) begin
          state_d = ST_DONE;
        end else if (idx_p1 < {1'b0, count_q}) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IW-1:0];
          state_d = ST_RM_SHIFT;
        end else begin
          count_d = count_m1;
          state_d = ST_DONE;
        end
      end

      ST_RM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IW-1:0];
        wr_data = rd_data;
        idx_d   = idx_p1[CW-1:0];
        if (idx_p2 < {1'b0, count_q}) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[IW-1:0];
        end else begin
          count_d = count_m1;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fp32  = 32'(fpos_q);
  assign op32  = 32'(opay_q);
  assign cnt32 = 32'(count_q);

  assign rsp_o.status         = st_q;
  assign rsp_o.found_position = fp32[7:0];
  assign rsp_o.entry_key      = okey_q;
  assign rsp_o.entry_payload  = op32[15:0];
  assign rsp_o.entry_count    = cnt32[8:0];

endmodule

[src/sorted_key_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_top: sorted key table with binary search
// Keeps up to CAPACITY entries sorted by ascending signed key and serves
// insert, search, remove and read requests from a single entry memory.
// ----------------------------------------------------------------------------
// Usage: a request transaction enters on in_valid_i / in_stall_o with
// in_data_i, and exactly one result transaction leaves on out_valid_o /
// out_stall_i with out_data_o. A transaction completes on a clock edge with
// valid high and stall low. One request is worked on at a time, and
// in_stall_o stays high until its result has been handed to the output
// register. Each cycle moves one entry. A search probe reads its entry in
// ST_SRCH_RD and compares it on the shared comparator in ST_SRCH_CMP, for at
// most log2 of the count plus one probes. Insert shifts every entry with a
// greater key up, remove shifts every entry behind the removed one down, and
// a read or a rejected request moves none. While a result waits under
// out_stall_i, the next request is still accepted and runs; it holds its own
// result until the output register frees. Reset empties the table and clears
// both channels; stored entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skt_pkg::skt_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skt_pkg::skt_rsp_t out_data_o
);
  import skt_pkg::*;

  logic     req_ready;
  logic     rsp_valid;
  logic     rsp_free;
  skt_rsp_t rsp;

  logic     out_valid_q, out_valid_d;
  skt_rsp_t out_data_q;

  skt_ctrl #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_free_i  (rsp_free),
    .rsp_o       (rsp)
  );

  assign in_stall_o = !req_ready;
  assign rsp_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_free) begin
      out_valid_d = rsp_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_free && rsp_valid) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[bench/sorted_key_table_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_top_tb: self-checking bench for the sorted key table
// A shadow copy of the table predicts every response. Requests go in as
// directed cases and then as random traffic that fills the table to
// capacity and drains it again. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
import skt_pkg::*;

class key_table_mirror;
  localparam int CAP = CAPACITY_DEF;

  logic signed [31:0] key_row [CAP];
  logic [15:0]        pay_row [CAP];
  int                 fill;
  skt_rsp_t           pending_rsp_q [$];
  int unsigned        mismatches;

  function new();
    fill       = 0;
    mismatches = 0;
  endfunction

  function void log_request(skt_req_t req);
    skt_rsp_t rsp;
    int       at;
    int       lo;
    int       hi;
    int       mid;
    bit       hit;
    rsp = '0;
    case (req.req_type)
      REQ_INSERT: begin
        if (fill >= CAP) begin
          rsp.status = STAT_FULL;
        end else begin
          at = fill;
          while (at > 0 && $signed(req.key) < $signed(key_row[at-1])) begin
            key_row[at] = key_row[at-1];
            pay_row[at] = pay_row[at-1];
            at--;
          end
          key_row[at] = req.key;
          pay_row[at] = req.payload;
          fill++;
          rsp.found_position = 8'(at);
          rsp.entry_key      = req.key;
          rsp.entry_payload  = req.payload;
        end
      end
      REQ_SEARCH: begin
        hit = 1'b0;
        lo  = 0;
        hi  = fill - 1;
        while (!hit && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (key_row[mid] == req.key) begin
            hit = 1'b1;
            rsp.found_position = 8'(mid);
            rsp.entry_key      = key_row[mid];
            rsp.entry_payload  = pay_row[mid];
          end else if ($signed(req.key) < $signed(key_row[mid])) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
        if (!hit) rsp.status = STAT_MISS;
      end
      default: begin
        if (int'(req.position) >= fill) begin
          rsp.status = STAT_RANGE;
        end else begin
          rsp.found_position = req.position;
          rsp.entry_key      = key_row[req.position];
          rsp.entry_payload  = pay_row[req.position];
          if (req.req_type == REQ_REMOVE) begin
            for (int i = req.position; i + 1 < fill; i++) begin
              key_row[i] = key_row[i+1];
              pay_row[i] = pay_row[i+1];
            end
            fill--;
          end
        end
      end
    endcase
    rsp.entry_count = 9'(fill);
    pending_rsp_q.push_back(rsp);
  endfunction

  task report(string msg);
    if (mismatches < 100) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_response(skt_rsp_t got);
    skt_rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      report("response transaction with no request outstanding");
      return;
    end
    want = pending_rsp_q.pop_front();
    if (got.status !== want.status)
      report($sformatf("status got %0d expected %0d", got.status, want.status));
    if (got.found_position !== want.found_position)
      report($sformatf("found_position got %0d expected %0d",
                       got.found_position, want.found_position));
    if (got.entry_key !== want.entry_key)
      report($sformatf("entry_key got %0d expected %0d", got.entry_key, want.entry_key));
    if (got.entry_payload !== want.entry_payload)
      report($sformatf("entry_payload got %h expected %h",
                       got.entry_payload, want.entry_payload));
    if (got.entry_count !== want.entry_count)
      report($sformatf("entry_count got %0d expected %0d",
                       got.entry_count, want.entry_count));
  endtask
endclass

module sorted_key_table_top_tb;

  localparam int          CAP        = CAPACITY_DEF;
  localparam int unsigned LIMIT      = 2_000_000;
  localparam int          MODE_MIX   = 0;
  localparam int          MODE_FILL  = 1;
  localparam int          MODE_DRAIN = 2;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  skt_req_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  skt_rsp_t out_data_o;

  key_table_mirror mirror = new();
  bit              idle_on = 1'b1;
  int unsigned     cycles  = 0;

  sorted_key_table_top #(
    .CAPACITY     (CAP),
    .PAYLOAD_BITS (PAYLOAD_BITS_DEF)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever @(posedge clk_i) begin
      cycles++;
      if (cycles > LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic skt_req_t make_req(logic [1:0] kind, logic signed [31:0] key,
                                        logic [15:0] pay, logic [7:0] pos);
    skt_req_t r;
    r.req_type = kind;
    r.key      = key;
    r.payload  = pay;
    r.position = pos;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_key();
    int unsigned sel;
    int          base;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      base = int'($urandom_range(0, 16)) - 8;
      return base;
    end
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (sel >= 8 && mirror.fill > 0) begin
      base = mirror.key_row[$urandom_range(0, mirror.fill - 1)];
      return base + int'($urandom_range(0, 2)) - 1;
    end
    return $urandom;
  endfunction

  function automatic skt_req_t draw_request(int mode);
    skt_req_t    r;
    int unsigned roll;
    r.key      = pick_key();
    r.payload  = 16'($urandom);
    r.position = 8'($urandom);
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  r.req_type = roll < 80 ? REQ_INSERT : (roll < 90 ? REQ_SEARCH : REQ_READ);
      MODE_DRAIN: r.req_type = roll < 70 ? REQ_REMOVE : (roll < 85 ? REQ_SEARCH : REQ_READ);
      default:    r.req_type = roll < 35 ? REQ_INSERT : (roll < 65 ? REQ_SEARCH :
                               (roll < 80 ? REQ_REMOVE : REQ_READ));
    endcase
    if (r.req_type == REQ_SEARCH && mirror.fill > 0 && $urandom_range(0, 9) < 6)
      r.key = mirror.key_row[$urandom_range(0, mirror.fill - 1)];
    if (r.req_type == REQ_REMOVE || r.req_type == REQ_READ) begin
      roll = $urandom_range(0, 9);
      if (mirror.fill > 0 && roll < 8)
        r.position = 8'($urandom_range(0, mirror.fill - 1));
      else if (roll == 8 && mirror.fill < CAP)
        r.position = 8'(mirror.fill);
    end
    return r;
  endfunction

  task automatic push_request(skt_req_t req);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    mirror.log_request(req);
  endtask

  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 150 || taken == 600) hold = 300;
      else hold = idle_on ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      mirror.check_response(out_data_o);
      taken++;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(make_req(REQ_SEARCH, 32'sd0, 16'h0000, 8'd0));
    push_request(make_req(REQ_READ,   32'sd0, 16'h0000, 8'd0));
    push_request(make_req(REQ_REMOVE, 32'sd0, 16'h0000, 8'd255));
    push_request(make_req(REQ_INSERT, KEY_MAX, 16'hFFFF, 8'd0));
    push_request(make_req(REQ_INSERT, KEY_MIN, 16'h0000, 8'd255));
    push_request(make_req(REQ_INSERT, 32'sd0, 16'h1234, 8'd0));
    push_request(make_req(REQ_INSERT, 32'sd0, 16'h4321, 8'd0));
    push_request(make_req(REQ_INSERT, -32'sd1, 16'hAAAA, 8'd0));
    push_request(make_req(REQ_INSERT, 32'sd5, 16'h5555, 8'd0));
    push_request(make_req(REQ_SEARCH, 32'sd0, 16'h0000, 8'd0));
    push_request(make_req(REQ_SEARCH, KEY_MIN, 16'h0000, 8'd0));
    push_request(make_req(REQ_SEARCH, KEY_MAX, 16'h0000, 8'd0));
    push_request(make_req(REQ_SEARCH, 32'sd3, 16'h0000, 8'd0));
    push_request(make_req(REQ_READ,   32'sd0, 16'h0000, 8'd0));
    push_request(make_req(REQ_READ,   32'sd0, 16'h0000, 8'd5));
    push_request(make_req(REQ_READ,   32'sd0, 16'h0000, 8'd6));
    push_request(make_req(REQ_READ,   32'sd0, 16'h0000, 8'd255));
    push_request(make_req(REQ_REMOVE, 32'sd0, 16'h0000, 8'd0));
    push_request(make_req(REQ_REMOVE, 32'sd0, 16'h0000, 8'd2));
    push_request(make_req(REQ_REMOVE, 32'sd0, 16'h0000, 8'd3));
    push_request(make_req(REQ_SEARCH, KEY_MIN, 16'h0000, 8'd0));
    push_request(make_req(REQ_INSERT, KEY_MIN, 16'hFFFF, 8'd255));

    repeat (150) push_request(draw_request(MODE_MIX));
    idle_on = 1'b0;
    repeat (100) push_request(draw_request(MODE_MIX));
    idle_on = 1'b1;
    while (mirror.fill < CAP) push_request(draw_request(MODE_FILL));
    repeat (30) push_request(draw_request(MODE_FILL));
    while (mirror.fill > 0) push_request(draw_request(MODE_DRAIN));
    repeat (200) push_request(draw_request(MODE_MIX));
    in_valid_i <= 1'b0;

    while (mirror.pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
src/skt_pkg.sv
src/skt_cmp.sv
src/skt_store.sv
src/skt_ctrl.sv
src/sorted_key_table_top.sv
bench/sorted_key_table_top_tb.sv
